// ===== rtl/core/sle_pkg.sv =====
// Shared types and constants for the sorted list engine.
// No dependencies; used by sle_ctrl, sorted_list_engine, sle_checker and tb.
`timescale 1ns / 1ps

package sle_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int ACTION_W     = 3;
    localparam int POS_W        = 7;
    localparam int CNT_OUT_W    = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT     = 3'd0,
        ACT_REMOVE_MIN = 3'd1,
        ACT_REMOVE_MAX = 3'd2,
        ACT_REMOVE_VAL = 3'd3,
        ACT_READ_POS   = 3'd4,
        ACT_COUNT      = 3'd5
    } action_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] value;
        logic [CNT_OUT_W-1:0]     count;
    } res_t;

endpackage

// ===== rtl/core/sle_ram.sv =====
// Single-port-write, single-port-read memory holding the sorted values.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module sle_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sle_ctrl.sv =====
// Sequencer that walks the sorted memory: search, shift up, shift down and fetch.
// Depends on sle_pkg; drives the ports of sle_ram.
`timescale 1ns / 1ps

module sle_ctrl #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sle_pkg::ACTION_W-1:0]     in_action,
    input  logic signed [sle_pkg::DATA_W-1:0] in_value,
    input  logic [sle_pkg::POS_W-1:0]        in_position,
    output logic                             res_valid,
    input  logic                             res_ready,
    output sle_pkg::res_t                    res,
    output logic                             mem_we,
    output logic [ADDR_W-1:0]                mem_waddr,
    output logic [sle_pkg::DATA_W-1:0]       mem_wdata,
    output logic [ADDR_W-1:0]                mem_raddr,
    input  logic [sle_pkg::DATA_W-1:0]       mem_rdata
);

    localparam int PW = (CNT_W > sle_pkg::POS_W) ? CNT_W : sle_pkg::POS_W;

    typedef enum logic [3:0] {
        IDLE,
        DISPATCH,
        SHIFT_UP,
        INS_PUT,
        FETCH_MIN,
        FETCH_ONE,
        SCAN,
        SHIFT_DN,
        DONE
    } state_t;

    state_t                            state_reg, state_next;
    sle_pkg::action_t                  act_reg, act_next;
    logic signed [sle_pkg::DATA_W-1:0] val_reg, val_next;
    logic [sle_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [ADDR_W-1:0]                 idx_reg, idx_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic                              ok_reg, ok_next;
    logic signed [sle_pkg::DATA_W-1:0] out_reg, out_next;

    logic [ADDR_W-1:0] cnt_m1;
    logic [ADDR_W-1:0] idx_p1;
    logic              full;
    logic              empty;
    logic              pos_ok;
    logic              in_fire;

    assign cnt_m1  = ADDR_W'(count_reg - CNT_W'(1));
    assign idx_p1  = ADDR_W'(idx_reg + ADDR_W'(1));
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ok  = (pos_reg != '0) && (PW'(pos_reg) <= PW'(count_reg));
    assign in_fire = in_valid && in_ready;

    assign in_ready  = (state_reg == IDLE);
    assign res_valid = (state_reg == DONE);
    assign res.ok    = ok_reg;
    assign res.value = out_reg;
    assign res.count = sle_pkg::CNT_OUT_W'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        out_next   = out_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = val_reg;
        mem_raddr  = idx_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (in_fire)
                begin
                    act_next   = sle_pkg::action_t'(in_action);
                    val_next   = in_value;
                    pos_next   = in_position;
                    ok_next    = 1'b0;
                    out_next   = '0;
                    state_next = DISPATCH;
                end
            end
            DISPATCH:
            begin
                unique case (act_reg)
                    sle_pkg::ACT_INSERT:
                    begin
                        if (full)
                        begin
                            state_next = DONE;
                        end
                        else if (empty)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            count_next = count_reg + CNT_W'(1);
                            ok_next    = 1'b1;
                            state_next = DONE;
                        end
                        else
                        begin
                            mem_raddr  = cnt_m1;
                            idx_next   = ADDR_W'(count_reg);
                            state_next = SHIFT_UP;
                        end
                    end
                    sle_pkg::ACT_REMOVE_MIN:
                    begin
                        mem_raddr  = '0;
                        state_next = empty ? DONE : FETCH_MIN;
                    end
                    sle_pkg::ACT_REMOVE_MAX:
                    begin
                        mem_raddr  = cnt_m1;
                        state_next = empty ? DONE : FETCH_ONE;
                    end
                    sle_pkg::ACT_REMOVE_VAL:
                    begin
                        mem_raddr  = '0;
                        idx_next   = '0;
                        state_next = empty ? DONE : SCAN;
                    end
                    sle_pkg::ACT_READ_POS:
                    begin
                        mem_raddr  = ADDR_W'(pos_reg - sle_pkg::POS_W'(1));
                        state_next = pos_ok ? FETCH_ONE : DONE;
                    end
                    sle_pkg::ACT_COUNT:
                    begin
                        ok_next    = 1'b1;
                        state_next = DONE;
                    end
                    default:
                    begin
                        state_next = DONE;
                    end
                endcase
            end
            SHIFT_UP:
            begin
                mem_we = 1'b1;
                if ($signed(mem_rdata) < val_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                    state_next = DONE;
                end
                else
                begin
                    mem_wdata = mem_rdata;
                    idx_next  = ADDR_W'(idx_reg - ADDR_W'(1));
                    mem_raddr = ADDR_W'(idx_reg - ADDR_W'(2));
                    if (idx_reg == ADDR_W'(1))
                    begin
                        state_next = INS_PUT;
                    end
                end
            end
            INS_PUT:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                ok_next    = 1'b1;
                state_next = DONE;
            end
            FETCH_MIN:
            begin
                out_next  = $signed(mem_rdata);
                idx_next  = '0;
                mem_raddr = ADDR_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    count_next = '0;
                    ok_next    = 1'b1;
                    state_next = DONE;
                end
                else
                begin
                    state_next = SHIFT_DN;
                end
            end
            FETCH_ONE:
            begin
                out_next = $signed(mem_rdata);
                ok_next  = 1'b1;
                if (act_reg == sle_pkg::ACT_REMOVE_MAX)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = DONE;
            end
            SCAN:
            begin
                mem_raddr = idx_p1;
                if ($signed(mem_rdata) == val_reg)
                begin
                    out_next = val_reg;
                    if (idx_reg == cnt_m1)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        ok_next    = 1'b1;
                        state_next = DONE;
                    end
                    else
                    begin
                        state_next = SHIFT_DN;
                    end
                end
                else if (idx_reg == cnt_m1)
                begin
                    state_next = DONE;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end
            SHIFT_DN:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                mem_raddr = ADDR_W'(idx_reg + ADDR_W'(2));
                idx_next  = idx_p1;
                if (idx_p1 == cnt_m1)
                begin
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                    state_next = DONE;
                end
            end
            DONE:
            begin
                if (res_ready)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            count_reg <= '0;
            ok_reg    <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.ok |-> res.value == '0)
        else $error("failed transaction carries a nonzero value");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE) && !in_fire |=> $stable(count_reg))
        else $error("entry count changed while idle");

    a_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DISPATCH) && (act_reg == sle_pkg::ACT_INSERT) && full
        |=> (state_reg == DONE) && !ok_reg)
        else $error("insert into a full store did not fail");

endmodule

// ===== rtl/core/sorted_list_engine.sv =====
// Top level of the sorted list engine: stream ports, sequencer, memory, output register.
// Depends on sle_pkg, sle_ram and sle_ctrl.
//
// Channel  | Direction | Fields (low bit first)
// s_axis   | in        | tuser: action[2:0]; tdata: value[31:0], position[38:32], zero fill to 40
// m_axis   | out       | tdata: ok[0], value_out[32:1], count[39:33]
//
// Count and failures found at dispatch go straight to done; remove largest and read position
// also pass a fetch state; insert into a non-empty list, remove smallest and remove value walk
// the entries, set by the single memory read port that steps one entry per cycle.
// One operation is in progress at a time; a stalled result holds the sequencer.
// Reset clears the entry count and the sequencer; the memory needs no clearing.
// A result waits in the output register while the next transaction is worked on.
`timescale 1ns / 1ps

module sorted_list_engine #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,   // action
    input  logic [39:0] s_axis_tdata,   // value, position, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // ok, value_out, count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic                       res_valid;
    logic                       res_ready;
    sle_pkg::res_t              res;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [sle_pkg::DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [sle_pkg::DATA_W-1:0] mem_rdata;

    logic          out_full_reg, out_full_next;
    sle_pkg::res_t out_data_reg, out_data_next;

    sle_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser),
        .in_value    (s_axis_tdata[31:0]),
        .in_position (s_axis_tdata[38:32]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    sle_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W),
        .DATA_W (sle_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_full_reg || m_axis_tready;

    always_comb
    begin
        out_full_next = out_full_reg;
        out_data_next = out_data_reg;
        if (m_axis_tready)
        begin
            out_full_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_full_next = 1'b1;
            out_data_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else
        begin
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_full_reg;
    assign m_axis_tdata  = {out_data_reg.count, out_data_reg.value, out_data_reg.ok};

endmodule

// ===== verif/sle_checker.sv =====
// Scoreboard for the sorted list engine: predicts each result from the accepted requests.
// Depends on sle_pkg; instantiated by tb beside sorted_list_engine.
`timescale 1ns / 1ps

module sle_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,   // action
    input  logic [39:0] s_axis_tdata,   // value, position, zero fill
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // ok, value_out, count
    output int          errors,
    output int          outstanding,
    output int          compared,
    output int          refused_inserts,
    output int          fill_level
);

    logic signed [sle_pkg::DATA_W-1:0] sorted_vals [sle_pkg::CAPACITY_DEF];
    int                                held;
    sle_pkg::res_t                     pending_answers [$];

    assign fill_level = held;

    function automatic sle_pkg::res_t apply_list_op(
        input logic [sle_pkg::ACTION_W-1:0]     act,
        input logic signed [sle_pkg::DATA_W-1:0] v,
        input logic [sle_pkg::POS_W-1:0]        pos);
        sle_pkg::res_t r;
        int            at;
        int            i;
        r = '0;
        case (act)
            sle_pkg::ACT_INSERT:
            begin
                if (held < sle_pkg::CAPACITY_DEF)
                begin
                    at = 0;
                    while (at < held && sorted_vals[at] < v)
                        at++;
                    for (i = held; i > at; i--)
                        sorted_vals[i] = sorted_vals[i-1];
                    sorted_vals[at] = v;
                    held++;
                    r.ok = 1'b1;
                end
                else
                begin
                    refused_inserts++;
                end
            end
            sle_pkg::ACT_REMOVE_MIN:
            begin
                if (held > 0)
                begin
                    r.ok    = 1'b1;
                    r.value = sorted_vals[0];
                    for (i = 0; i < held - 1; i++)
                        sorted_vals[i] = sorted_vals[i+1];
                    held--;
                end
            end
            sle_pkg::ACT_REMOVE_MAX:
            begin
                if (held > 0)
                begin
                    r.ok    = 1'b1;
                    r.value = sorted_vals[held-1];
                    held--;
                end
            end
            sle_pkg::ACT_REMOVE_VAL:
            begin
                at = -1;
                for (i = 0; i < held; i++)
                begin
                    if (at < 0 && sorted_vals[i] == v)
                        at = i;
                end
                if (at >= 0)
                begin
                    r.ok    = 1'b1;
                    r.value = v;
                    for (i = at; i < held - 1; i++)
                        sorted_vals[i] = sorted_vals[i+1];
                    held--;
                end
            end
            sle_pkg::ACT_READ_POS:
            begin
                if (pos >= 1 && pos <= held)
                begin
                    r.ok    = 1'b1;
                    r.value = sorted_vals[pos-1];
                end
            end
            sle_pkg::ACT_COUNT:
            begin
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.count = sle_pkg::CNT_OUT_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        sle_pkg::res_t want;
        if (!rst_n)
        begin
            held            = 0;
            errors          = 0;
            compared        = 0;
            refused_inserts = 0;
            pending_answers.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("Result transaction arrived with no request outstanding.");
                    errors++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    compared++;
                    if (m_axis_tdata[0] !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, m_axis_tdata[0]);
                        errors++;
                    end
                    if (m_axis_tdata[32:1] !== want.value)
                    begin
                        $error("value_out: expected %0d, got %0d", want.value,
                               $signed(m_axis_tdata[32:1]));
                        errors++;
                    end
                    if (m_axis_tdata[39:33] !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count,
                               m_axis_tdata[39:33]);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_answers.push_back(apply_list_op(s_axis_tuser,
                                                        s_axis_tdata[31:0],
                                                        s_axis_tdata[38:32]));
        end
        outstanding = pending_answers.size();
    end

endmodule

// ===== verif/tb.sv =====
// Top-level testbench for sorted_list_engine: clock, reset, request and result traffic.
// Depends on sle_pkg, sorted_list_engine and sle_checker.
`timescale 1ns / 1ps

module tb;

    localparam logic [sle_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [sle_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 2 * sle_pkg::CAPACITY_DEF + 20;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    int errors;
    int outstanding;
    int compared;
    int refused_inserts;
    int fill_level;
    int sent;
    int stall_cycles;
    bit no_gaps;
    logic signed [sle_pkg::DATA_W-1:0] recent_vals [16];

    sorted_list_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sle_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .errors          (errors),
        .outstanding     (outstanding),
        .compared        (compared),
        .refused_inserts (refused_inserts),
        .fill_level      (fill_level)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_len();
        return no_gaps ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic send_op(input logic [sle_pkg::ACTION_W-1:0] act,
                           input logic signed [sle_pkg::DATA_W-1:0] v,
                           input logic [sle_pkg::POS_W-1:0] pos);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {1'b0, pos, v};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [sle_pkg::ACTION_W-1:0] pick_action(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == MODE_FILL && r < 80)
            return sle_pkg::ACT_INSERT;
        if (mode == MODE_DRAIN && r < 75)
            return (r < 25) ? sle_pkg::ACT_REMOVE_MIN :
                   (r < 50) ? sle_pkg::ACT_REMOVE_MAX : sle_pkg::ACT_REMOVE_VAL;
        r = $urandom_range(0, 99);
        if (r < 30) return sle_pkg::ACT_INSERT;
        if (r < 42) return sle_pkg::ACT_REMOVE_MIN;
        if (r < 54) return sle_pkg::ACT_REMOVE_MAX;
        if (r < 70) return sle_pkg::ACT_REMOVE_VAL;
        if (r < 86) return sle_pkg::ACT_READ_POS;
        if (r < 96) return sle_pkg::ACT_COUNT;
        if (r < 98) return ACT_SPARE_A;
        return ACT_SPARE_B;
    endfunction

    function automatic logic signed [sle_pkg::DATA_W-1:0] pick_value(
        input logic [sle_pkg::ACTION_W-1:0] act);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 || (act == sle_pkg::ACT_REMOVE_VAL && r < 75))
            return recent_vals[$urandom_range(0, 15)];
        if (r < 60)
            return $signed($urandom_range(0, 20)) - 10;
        if (r < 70)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [sle_pkg::POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return sle_pkg::POS_W'($urandom_range(1, (fill_level > 0) ? fill_level : 1));
        if (r < 80) return '0;
        if (r < 90) return sle_pkg::POS_W'(fill_level + 1);
        return sle_pkg::POS_W'($urandom_range(0, 127));
    endfunction

    task automatic random_op(input int mode, inout int counted);
        logic [sle_pkg::ACTION_W-1:0]      act;
        logic signed [sle_pkg::DATA_W-1:0] v;
        act = pick_action(mode);
        v   = pick_value(act);
        if (act == sle_pkg::ACT_INSERT && $urandom_range(0, 1) == 1)
            recent_vals[$urandom_range(0, 15)] = v;
        send_op(act, v, pick_position());
        if (act != ACT_SPARE_A && act != ACT_SPARE_B)
            counted++;
    endtask

    // Result side: stall a random number of cycles, then take one transaction.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int stall;
            stall = idle_len();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
                         stall_cycles, outstanding);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int counted;
        int phase;
        int len;
        int mode;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        no_gaps       = 1'b0;
        sent          = 0;
        stall_cycles  = 0;
        counted       = 0;
        recent_vals   = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 2, 3, 5,
                          -2, -3, 7, 100, -100, 12345, 42, -42};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_op(sle_pkg::ACT_COUNT,      0, 0);
        send_op(sle_pkg::ACT_REMOVE_MIN, 0, 0);
        send_op(sle_pkg::ACT_REMOVE_MAX, 0, 0);
        send_op(sle_pkg::ACT_REMOVE_VAL, 0, 0);
        send_op(sle_pkg::ACT_READ_POS,   0, 1);
        send_op(sle_pkg::ACT_INSERT,     32'sh7FFF_FFFF, 0);
        send_op(sle_pkg::ACT_INSERT,     32'sh8000_0000, 0);
        send_op(sle_pkg::ACT_INSERT,     0, 0);
        send_op(sle_pkg::ACT_INSERT,     -1, 0);
        send_op(sle_pkg::ACT_INSERT,     0, 0);
        send_op(sle_pkg::ACT_READ_POS,   0, 0);
        send_op(sle_pkg::ACT_READ_POS,   0, 1);
        send_op(sle_pkg::ACT_READ_POS,   0, 5);
        send_op(sle_pkg::ACT_READ_POS,   0, 6);
        send_op(sle_pkg::ACT_READ_POS,   0, 127);
        send_op(sle_pkg::ACT_REMOVE_VAL, 12345, 0);
        send_op(sle_pkg::ACT_REMOVE_VAL, 0, 0);
        send_op(ACT_SPARE_A,             32'sh7FFF_FFFF, 127);
        send_op(ACT_SPARE_B,             -1, 127);
        send_op(sle_pkg::ACT_REMOVE_MIN, 0, 0);
        send_op(sle_pkg::ACT_REMOVE_MAX, 0, 0);
        send_op(sle_pkg::ACT_COUNT,      0, 0);
        send_op(sle_pkg::ACT_REMOVE_VAL, -1, 0);
        send_op(sle_pkg::ACT_REMOVE_MIN, 0, 0);
        send_op(sle_pkg::ACT_REMOVE_MIN, 0, 0);

        // Alternate phases weighted toward filling past capacity, toward draining to empty, and mixed traffic.
        phase = 0;
        while (counted < RANDOM_ITEMS)
        begin
            mode    = phase % 3;
            len     = $urandom_range(100, 140);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (len)
                random_op(mode, counted);
            phase++;
        end
        no_gaps = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d requests, compared %0d results, %0d inserts refused on a full list.",
                 sent, compared, refused_inserts);
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sle_pkg.sv
rtl/core/sle_ram.sv
rtl/core/sle_ctrl.sv
rtl/core/sorted_list_engine.sv
verif/sle_checker.sv
verif/tb.sv
